// ===== rtl/core/bma_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bma_pkg
// Shared constants, state encoding and controller/datapath bundles for the
// boxcar moving average unit.
// ----------------------------------------------------------------------------
package bma_pkg;

	localparam int MAX_WINDOW = 256;
	localparam int SAMPLE_W   = 16;
	localparam int LEN_W      = 9;
	localparam int POS_W      = $clog2(MAX_WINDOW);
	localparam int TOTAL_W    = 25;
	localparam int MAG_W      = TOTAL_W - 1;
	localparam int REM_W      = LEN_W;
	localparam int CNT_W      = $clog2(MAG_W);

	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(MAG_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SETUP,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic accept;
		logic update;
		logic setup;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_busy;
	} status_t;

endpackage
`default_nettype wire

// ===== rtl/core/boxcar_moving_average_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// boxcar_moving_average_unit
// Moving average of signed 16-bit samples over a programmable window.
// ----------------------------------------------------------------------------
// Each item runs from acceptance to a loaded result in these steps: the oldest
// ring entry is read at the accepting edge, then ST_UPDATE updates the running
// total and the ring, ST_SETUP sets up the divider, 24 iterations of the
// radix-2 restoring divider follow and ST_FINISH loads the output register
// once the output side is not stalling. A new item is accepted in the cycle
// after the result is loaded; no new sample is taken before the last is done.
// Writing window_length (clamped to 1..256) clears the history at once; write
// it only while the unit is idle.
module boxcar_moving_average_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                window_length_wr_en,
	input  wire logic        [bma_pkg::LEN_W-1:0]    window_length,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [bma_pkg::SAMPLE_W-1:0] sample_in,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed      [bma_pkg::SAMPLE_W-1:0] average_out
);
	import bma_pkg::*;

	cmd_t    cmd;
	status_t status;

	bma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	bma_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.window_length_wr_en (window_length_wr_en),
		.window_length       (window_length),
		.sample_in           (sample_in),
		.out_stall           (out_stall),
		.out_valid           (out_valid),
		.average_out         (average_out),
		.cmd                 (cmd),
		.status              (status)
	);

endmodule
`default_nettype wire

// ===== rtl/core/bma_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/bma_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bma_ctrl
// Sequencer for one item: ring read, total update, divider setup, divide
// iterations, result hand-off.
// ----------------------------------------------------------------------------
module bma_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire bma_pkg::status_t status,
	output bma_pkg::cmd_t         cmd
);
	import bma_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_UPDATE;
			end
			ST_UPDATE: state_next = ST_SETUP;
			ST_SETUP:  state_next = ST_DIVIDE;
			ST_DIVIDE: begin
				if (status.div_last) state_next = ST_FINISH;
			end
			ST_FINISH: begin
				if (!status.out_busy) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_UPDATE: cmd.update   = 1'b1;
			ST_SETUP:  cmd.setup    = 1'b1;
			ST_DIVIDE: cmd.div_step = 1'b1;
			ST_FINISH: cmd.load_out = !status.out_busy;
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/bma_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bma_dp
// Datapath: length register, sample ring, running total, radix-2 restoring
// divider and output register.
// ----------------------------------------------------------------------------
module bma_dp (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  window_length_wr_en,
	input  wire logic        [bma_pkg::LEN_W-1:0]      window_length,
	input  wire logic signed [bma_pkg::SAMPLE_W-1:0]   sample_in,
	input  wire logic                                  out_stall,
	output logic                                       out_valid,
	output logic signed      [bma_pkg::SAMPLE_W-1:0]   average_out,
	input  wire bma_pkg::cmd_t                         cmd,
	output bma_pkg::status_t                           status
);
	import bma_pkg::*;

	logic        [LEN_W-1:0]    len_q;
	logic        [POS_W-1:0]    pos_q;
	logic                       wrapped_q;
	logic signed [TOTAL_W-1:0]  total_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       neg_q;
	logic        [MAG_W-1:0]    quo_q;
	logic        [REM_W-1:0]    rem_q;
	logic        [CNT_W-1:0]    cnt_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] avg_q;

	logic        [SAMPLE_W-1:0] ram_rdata;
	logic signed [SAMPLE_W-1:0] old_sample;
	logic signed [TOTAL_W-1:0]  total_next;
	logic        [LEN_W-1:0]    pos_inc;
	logic                       pos_wrap;
	logic        [LEN_W-1:0]    len_clamped;
	logic        [MAG_W-1:0]    total_abs;
	logic        [REM_W:0]      trial;
	logic                       trial_ge;
	logic signed [TOTAL_W-1:0]  quo_signed;
	logic signed [SAMPLE_W-1:0] avg_sat;

	bma_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (pos_q),
		.wdata (sample_q),
		.re    (cmd.accept),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	// entries past the write point hold nothing until the ring wraps once
	assign old_sample = wrapped_q ? $signed(ram_rdata) : '0;
	assign total_next = total_q - TOTAL_W'(old_sample) + TOTAL_W'(sample_q);
	assign pos_inc    = LEN_W'(pos_q) + LEN_W'(1);
	assign pos_wrap   = pos_inc >= len_q;

	always_comb begin
		if (window_length == '0) begin
			len_clamped = LEN_W'(1);
		end else if (window_length > LEN_W'(MAX_WINDOW)) begin
			len_clamped = LEN_W'(MAX_WINDOW);
		end else begin
			len_clamped = window_length;
		end
	end

	assign total_abs = total_q[TOTAL_W-1] ? MAG_W'(-total_q) : MAG_W'(total_q);
	assign trial     = {rem_q, quo_q[MAG_W-1]};
	assign trial_ge  = trial >= (REM_W+1)'(len_q);

	assign quo_signed = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	always_comb begin
		if (quo_signed > TOTAL_W'(32767)) begin
			avg_sat = 16'sh7fff;
		end else if (quo_signed < -TOTAL_W'(32768)) begin
			avg_sat = 16'sh8000;
		end else begin
			avg_sat = quo_signed[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= LEN_W'(1);
			pos_q     <= '0;
			wrapped_q <= 1'b0;
			total_q   <= '0;
			cnt_q     <= '0;
		end else begin
			if (window_length_wr_en) begin
				len_q     <= len_clamped;
				pos_q     <= '0;
				wrapped_q <= 1'b0;
				total_q   <= '0;
			end else if (cmd.update) begin
				total_q <= total_next;
				if (pos_wrap) begin
					pos_q     <= '0;
					wrapped_q <= 1'b1;
				end else begin
					pos_q <= pos_inc[POS_W-1:0];
				end
			end
			if (cmd.setup) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample_in;
		end
		if (cmd.setup) begin
			neg_q <= total_q[TOTAL_W-1];
			quo_q <= total_abs;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[MAG_W-2:0], trial_ge};
			rem_q <= trial_ge ? REM_W'(trial - (REM_W+1)'(len_q)) : trial[REM_W-1:0];
		end
		if (cmd.load_out) begin
			avg_q <= avg_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign average_out     = avg_q;
	assign status.div_last = cnt_q == DIV_LAST;
	assign status.out_busy = out_valid_q && out_stall;

endmodule
`default_nettype wire
